// ===== sv/assert_macros.svh =====
// Assertion helpers; the using scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle out of reset.
`define HBSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hbsd assertion failed");

// Implication, antecedent then consequent.
`define HBSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbsd implication failed");

// Next-cycle implication.
`define HBSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbsd sequence failed");

`endif

// ===== sv/hbsd_pkg.sv =====
`timescale 1ns / 1ps

package hbsd_pkg;

    localparam int BYTE_W        = 8;
    localparam int MIN_W         = 4;
    localparam int FRAME_BYTES_W = 12;
    localparam int STATUS_W      = 2;
    localparam int SEQ_W         = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN    = 2'd3;

    localparam logic [BYTE_W-1:0] FLAG_RST   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h7D;
    localparam logic [BYTE_W-1:0] MASK_RST   = 8'h20;
    localparam logic [MIN_W-1:0]  MIN_RST    = 4'd6;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_MAX = 12'hFFF;

    localparam logic [STATUS_W-1:0] STATUS_GOOD  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CRC   = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [BYTE_W-1:0]        payload_byte;
        logic [BYTE_W-1:0]        address;
        logic [BYTE_W-1:0]        control;
        logic [STATUS_W-1:0]      status;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
    } result_t;

    // byte-wide CRC-16 update, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/hbsd_if.sv =====
`timescale 1ns / 1ps

interface hbsd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [hbsd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hbsd_result_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [hbsd_pkg::BYTE_W-1:0]        payload_byte;
    logic [hbsd_pkg::BYTE_W-1:0]        address;
    logic [hbsd_pkg::BYTE_W-1:0]        control;
    logic                              poll;
    logic [hbsd_pkg::SEQ_W-1:0]         tx_seq;
    logic [hbsd_pkg::SEQ_W-1:0]         recv_seq;
    logic                              is_info;
    logic                              is_supervisory;
    logic [hbsd_pkg::STATUS_W-1:0]      status;
    logic [hbsd_pkg::FRAME_BYTES_W-1:0] frame_bytes;
    logic                              last;

    modport source (output valid, output kind, output payload_byte, output address,
                    output control, output poll, output tx_seq, output recv_seq,
                    output is_info, output is_supervisory, output status,
                    output frame_bytes, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input address,
                    input control, input poll, input tx_seq, input recv_seq,
                    input is_info, input is_supervisory, input status,
                    input frame_bytes, input last, output ready);
endinterface

// ===== sv/hdlc_byte_stuffed_deframer.sv =====
`timescale 1ns / 1ps
// Result path: an accepted rx byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side is not stalled, with a byte-parallel CRC update.
// Bytes causing no result (flags that end no frame, escapes, header bytes) are consumed silently.
// Reset (rst_n low, async): config to 7E/7D/20/6, hunting for opening flag,
// CRC 0xFFFF, delay line, count and header holds cleared, both stages empty.
module hdlc_byte_stuffed_deframer #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hbsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hbsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    hbsd_byte_if.sink                            rx,
    hbsd_result_if.source                        res
);

    localparam int CW = COUNT_WIDTH;

    logic [hbsd_pkg::BYTE_W-1:0] flag_reg;
    logic [hbsd_pkg::BYTE_W-1:0] escape_reg;
    logic [hbsd_pkg::BYTE_W-1:0] mask_reg;
    logic [hbsd_pkg::MIN_W-1:0]  min_reg;

    logic                        in_valid_reg;
    logic [hbsd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    hbsd_pkg::result_t           result_reg;
    hbsd_pkg::result_t           result_next;

    logic                        esc_reg,      esc_next;
    logic                        in_frame_reg, in_frame_next;
    logic [15:0]                 crc_reg,      crc_next;
    logic [hbsd_pkg::BYTE_W-1:0] dly0_reg,     dly0_next;
    logic [hbsd_pkg::BYTE_W-1:0] dly1_reg,     dly1_next;
    logic [CW-1:0]               cnt_reg,      cnt_next;
    logic [hbsd_pkg::BYTE_W-1:0] addr_reg,     addr_next;
    logic [hbsd_pkg::BYTE_W-1:0] ctrl_reg,     ctrl_next;

    logic                        advance;
    logic                        fire;
    logic                        emit;
    logic                        take_en;
    logic [hbsd_pkg::BYTE_W-1:0] take_d;
    logic                        open_en;
    logic                        short_frame;
    logic                        cnt_sat_12;

    assign advance  = !out_valid_reg || res.ready;
    assign fire     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    assign short_frame = (({1'b0, cnt_reg} + (CW+1)'(2)) < (CW+1)'(min_reg));
    assign cnt_sat_12  = (CW'(cnt_reg) > CW'(hbsd_pkg::FRAME_BYTES_MAX));

    always_comb
    begin
        esc_next      = esc_reg;
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        dly0_next     = dly0_reg;
        dly1_next     = dly1_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        ctrl_next     = ctrl_reg;
        emit          = 1'b0;
        take_en       = 1'b0;
        take_d        = in_byte_reg;
        open_en       = 1'b0;
        result_next   = '0;

        if (!in_frame_reg)
        begin
            open_en = (in_byte_reg == flag_reg);
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            take_en  = 1'b1;
            take_d   = in_byte_reg ^ mask_reg;
        end
        else if (in_byte_reg == escape_reg)
        begin
            esc_next = 1'b1;
        end
        else if (in_byte_reg == flag_reg)
        begin
            if (cnt_reg != '0)
            begin
                emit                     = 1'b1;
                open_en                  = 1'b1;
                result_next.kind         = hbsd_pkg::KIND_END;
                result_next.address      = addr_reg;
                result_next.control      = ctrl_reg;
                result_next.frame_bytes  = cnt_sat_12 ? hbsd_pkg::FRAME_BYTES_MAX
                                                      : hbsd_pkg::FRAME_BYTES_W'(cnt_reg);
                if (short_frame)
                begin
                    result_next.status = hbsd_pkg::STATUS_SHORT;
                end
                else if ({dly1_reg, dly0_reg} != crc_reg)
                begin
                    result_next.status = hbsd_pkg::STATUS_CRC;
                end
                else
                begin
                    result_next.status = hbsd_pkg::STATUS_GOOD;
                end
            end
        end
        else
        begin
            take_en = 1'b1;
        end

        if (take_en)
        begin
            if (cnt_reg == '0)
            begin
                addr_next = take_d;
            end
            else if (cnt_reg == CW'(1))
            begin
                ctrl_next = take_d;
            end
            if (cnt_reg >= CW'(2))
            begin
                crc_next = hbsd_pkg::crc_update(crc_reg, dly0_reg);
                if (cnt_reg >= CW'(4))
                begin
                    emit                     = 1'b1;
                    result_next.kind         = hbsd_pkg::KIND_PAYLOAD;
                    result_next.payload_byte = dly0_reg;
                end
            end
            dly0_next = dly1_reg;
            dly1_next = take_d;
            if (cnt_reg != {CW{1'b1}})
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end

        if (open_en)
        begin
            in_frame_next = 1'b1;
            esc_next      = 1'b0;
            crc_next      = hbsd_pkg::CRC_INIT;
            dly0_next     = '0;
            dly1_next     = '0;
            cnt_next      = '0;
            addr_next     = '0;
            ctrl_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= hbsd_pkg::FLAG_RST;
            escape_reg <= hbsd_pkg::ESCAPE_RST;
            mask_reg   <= hbsd_pkg::MASK_RST;
            min_reg    <= hbsd_pkg::MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbsd_pkg::REG_FLAG:   flag_reg   <= cfg_data;
                hbsd_pkg::REG_ESCAPE: escape_reg <= cfg_data;
                hbsd_pkg::REG_MASK:   mask_reg   <= cfg_data;
                hbsd_pkg::REG_MIN:    min_reg    <= cfg_data[hbsd_pkg::MIN_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            esc_reg       <= 1'b0;
            in_frame_reg  <= 1'b0;
            crc_reg       <= hbsd_pkg::CRC_INIT;
            dly0_reg      <= '0;
            dly1_reg      <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            ctrl_reg      <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= fire && emit;
            end
            if (fire)
            begin
                esc_reg      <= esc_next;
                in_frame_reg <= in_frame_next;
                crc_reg      <= crc_next;
                dly0_reg     <= dly0_next;
                dly1_reg     <= dly1_next;
                cnt_reg      <= cnt_next;
                addr_reg     <= addr_next;
                ctrl_reg     <= ctrl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    // control decode; zero on payload items since control is zero there
    logic is_end;
    assign is_end = (result_reg.kind == hbsd_pkg::KIND_END);

    assign res.valid          = out_valid_reg;
    assign res.kind           = result_reg.kind;
    assign res.payload_byte   = result_reg.payload_byte;
    assign res.address        = result_reg.address;
    assign res.control        = result_reg.control;
    assign res.poll           = result_reg.control[4];
    assign res.tx_seq         = result_reg.control[3:1];
    assign res.recv_seq       = result_reg.control[7:5];
    assign res.is_info        = is_end && !result_reg.control[0];
    assign res.is_supervisory = (result_reg.control[1:0] == 2'b01);
    assign res.status         = result_reg.status;
    assign res.frame_bytes    = result_reg.frame_bytes;
    assign res.last           = is_end;

endmodule

// ===== sv/hbsd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hbsd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 kind,
    input logic                                 last,
    input logic [hbsd_pkg::BYTE_W-1:0]          payload_byte,
    input logic [hbsd_pkg::BYTE_W-1:0]          control,
    input logic                                 is_info,
    input logic [hbsd_pkg::STATUS_W-1:0]        status
);

    logic pay_out;
    logic end_out;
    logic pay_clean;
    logic end_clean;

    assign pay_out   = out_valid && (kind == hbsd_pkg::KIND_PAYLOAD);
    assign end_out   = out_valid && (kind == hbsd_pkg::KIND_END);
    assign pay_clean = (status == hbsd_pkg::STATUS_GOOD) && (control == '0) && !is_info;
    assign end_clean = (payload_byte == '0) && (is_info == !control[0]);

    `HBSD_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid)
    `HBSD_ASSERT_IMP(a_last_kind, out_valid, last == kind)
    `HBSD_ASSERT_IMP(a_payload_clean, pay_out, pay_clean)
    `HBSD_ASSERT_IMP(a_end_fields, end_out, end_clean)

endmodule

bind hdlc_byte_stuffed_deframer hbsd_checker u_hbsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .kind         (res.kind),
    .last         (res.last),
    .payload_byte (res.payload_byte),
    .control      (res.control),
    .is_info      (res.is_info),
    .status       (res.status)
);

// ===== tb/hdlc_byte_stuffed_deframer_tb.sv =====
`timescale 1ns / 1ps

module hdlc_byte_stuffed_deframer_tb;
    import hbsd_pkg::*;

    localparam int COUNT_BITS  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic                     kind;
        logic [BYTE_W-1:0]        payload_byte;
        logic [BYTE_W-1:0]        address;
        logic [BYTE_W-1:0]        control;
        logic                     poll;
        logic [SEQ_W-1:0]         tx_seq;
        logic [SEQ_W-1:0]         recv_seq;
        logic                     is_info;
        logic                     is_supervisory;
        logic [STATUS_W-1:0]      status;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
        logic                     last;
    } frame_event_t;

    typedef enum int {FCS_GOOD, FCS_BAD, FCS_NONE} fcs_mode_e;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hbsd_byte_if   rx_if ();
    hbsd_result_if res_if ();

    hdlc_byte_stuffed_deframer #(
        .COUNT_WIDTH(COUNT_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .rx(rx_if),
        .res(res_if)
    );

    // deframer model state
    logic [BYTE_W-1:0]     flag_cfg = FLAG_RST;
    logic [BYTE_W-1:0]     esc_cfg  = ESCAPE_RST;
    logic [BYTE_W-1:0]     mask_cfg = MASK_RST;
    logic [MIN_W-1:0]      min_cfg  = MIN_RST;
    logic                  esc_pending = 1'b0;
    logic                  in_frame = 1'b0;
    logic [15:0]           fcs = CRC_INIT;
    logic [BYTE_W-1:0]     fcs_line [2];
    logic [COUNT_BITS-1:0] byte_cnt = '0;
    logic [BYTE_W-1:0]     addr_hold = '0;
    logic [BYTE_W-1:0]     ctrl_hold = '0;

    frame_event_t      expected_events [$];
    logic [BYTE_W-1:0] line_bytes [$];
    int                bytes_queued = 0;
    int                bytes_accepted = 0;
    int                errors = 0;
    int                cycles = 0;
    int                stuff_odds = 8;
    int                burst_left = 1;
    int                gap_left = 0;
    int                stall_left = 0;
    int                stall_mode = 0;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void open_frame();
        in_frame = 1'b1;
        esc_pending = 1'b0;
        fcs = CRC_INIT;
        fcs_line[0] = '0;
        fcs_line[1] = '0;
        byte_cnt = '0;
        addr_hold = '0;
        ctrl_hold = '0;
    endfunction

    function automatic void take_data(input logic [7:0] d);
        frame_event_t ev;
        if (byte_cnt == 0)
        begin
            addr_hold = d;
        end
        else if (byte_cnt == 1)
        begin
            ctrl_hold = d;
        end
        if (byte_cnt >= 2)
        begin
            fcs = crc16_byte(fcs, fcs_line[0]);
            if (byte_cnt >= 4)
            begin
                ev = '0;
                ev.kind = KIND_PAYLOAD;
                ev.payload_byte = fcs_line[0];
                expected_events.push_back(ev);
            end
        end
        fcs_line[0] = fcs_line[1];
        fcs_line[1] = d;
        if (byte_cnt != '1)
        begin
            byte_cnt = byte_cnt + 1'b1;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] raw);
        frame_event_t ev;
        if (!in_frame)
        begin
            if (raw == flag_cfg)
            begin
                open_frame();
            end
            return;
        end
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            take_data(raw ^ mask_cfg);
            return;
        end
        if (raw == esc_cfg)
        begin
            esc_pending = 1'b1;
            return;
        end
        if (raw == flag_cfg)
        begin
            if (byte_cnt == 0)
            begin
                return;
            end
            ev = '0;
            ev.kind = KIND_END;
            ev.address = addr_hold;
            ev.control = ctrl_hold;
            ev.poll = ctrl_hold[4];
            ev.tx_seq = ctrl_hold[3:1];
            ev.recv_seq = ctrl_hold[7:5];
            ev.is_info = !ctrl_hold[0];
            ev.is_supervisory = (ctrl_hold[1:0] == 2'b01);
            if (int'(byte_cnt) + 2 < int'(min_cfg))
            begin
                ev.status = STATUS_SHORT;
            end
            else if ({fcs_line[1], fcs_line[0]} != fcs)
            begin
                ev.status = STATUS_CRC;
            end
            else
            begin
                ev.status = STATUS_GOOD;
            end
            ev.frame_bytes = (int'(byte_cnt) > 4095) ? FRAME_BYTES_MAX : FRAME_BYTES_W'(byte_cnt);
            ev.last = 1'b1;
            expected_events.push_back(ev);
            open_frame();
            return;
        end
        take_data(raw);
    endfunction

    // stimulus construction
    function automatic void push_raw(input logic [7:0] b);
        line_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void push_data(input logic [7:0] b);
        if (b == flag_cfg || b == esc_cfg || $urandom_range(0, stuff_odds - 1) == 0)
        begin
            push_raw(esc_cfg);
            push_raw(b ^ mask_cfg);
        end
        else
        begin
            push_raw(b);
        end
    endfunction

    function automatic void send_frame(input int body_len, input int fill, input fcs_mode_e mode);
        logic [15:0] acc;
        logic [7:0]  b;
        acc = CRC_INIT;
        for (int i = 0; i < body_len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            acc = crc16_byte(acc, b);
            push_data(b);
        end
        if (mode != FCS_NONE)
        begin
            if (mode == FCS_BAD)
            begin
                acc = acc ^ 16'($urandom_range(1, 65535));
            end
            push_data(acc[7:0]);
            push_data(acc[15:8]);
        end
        push_raw(flag_cfg);
    endfunction

    function automatic void send_noise(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                push_raw(flag_cfg);
            end
            else if (r < 50)
            begin
                push_raw(esc_cfg);
            end
            else
            begin
                push_raw(8'($urandom));
            end
        end
    endfunction

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FLAG:   flag_cfg = val;
            REG_ESCAPE: esc_cfg = val;
            REG_MASK:   mask_cfg = val;
            default:    min_cfg = val[MIN_W-1:0];
        endcase
    endtask

    task automatic apply_config(input logic [7:0] f, input logic [7:0] e, input logic [7:0] m,
                                input logic [MIN_W-1:0] mn);
        write_reg(REG_FLAG, f);
        write_reg(REG_ESCAPE, e);
        write_reg(REG_MASK, m);
        write_reg(REG_MIN, {4'b0000, mn});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("hdlc_byte_stuffed_deframer test failed");
            $finish;
        end
    end

    // line side: bursts with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                predict_byte(rx_if.rx_byte);
                bytes_accepted++;
            end
            if (!rx_if.valid || rx_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    rx_if.valid <= 1'b0;
                end
                else if (line_bytes.size() > 0)
                begin
                    rx_if.valid <= 1'b1;
                    rx_if.rx_byte <= line_bytes.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= (stall_left < 8);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        frame_event_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual kind %0d payload %0h",
                         $time, res_if.kind, res_if.payload_byte);
                errors++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("kind", want.kind, res_if.kind);
                check_field("payload_byte", want.payload_byte, res_if.payload_byte);
                check_field("address", want.address, res_if.address);
                check_field("control", want.control, res_if.control);
                check_field("poll", want.poll, res_if.poll);
                check_field("tx_seq", want.tx_seq, res_if.tx_seq);
                check_field("recv_seq", want.recv_seq, res_if.recv_seq);
                check_field("is_info", want.is_info, res_if.is_info);
                check_field("is_supervisory", want.is_supervisory, res_if.is_supervisory);
                check_field("status", want.status, res_if.status);
                check_field("frame_bytes", want.frame_bytes, res_if.frame_bytes);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    initial
    begin
        int          stop_at;
        int          r;
        bit          paused;
        logic [7:0]  f;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FLAG;
        cfg_data = '0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready = 1'b0;
        fcs_line[0] = '0;
        fcs_line[1] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // junk before the first flag, then empty pair
        push_raw(esc_cfg);
        push_raw(8'h00);
        push_raw(8'hFF);
        push_raw(esc_cfg);
        push_raw(flag_cfg);
        push_raw(flag_cfg);
        send_frame(1, -1, FCS_NONE);
        send_frame(0, -1, FCS_GOOD);
        send_frame(2, 8'h00, FCS_GOOD);
        send_frame(2, 8'hFF, FCS_GOOD);
        send_frame(3, -1, FCS_BAD);
        // escaped flag and escaped escape count as data
        push_raw(esc_cfg);
        push_raw(flag_cfg);
        push_raw(esc_cfg);
        push_raw(esc_cfg);
        push_raw(8'h5A);
        push_raw(flag_cfg);
        wait_idle();

        // flag equal to escape: frames never close
        apply_config(8'h55, 8'h55, 8'h0F, 4'd3);
        send_noise(30);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_config(8'h00, 8'hFF, 8'h00, 4'd0);
                1: apply_config(8'hFF, 8'h00, 8'hFF, 4'd15);
                2: apply_config(FLAG_RST, ESCAPE_RST, MASK_RST, MIN_RST);
                default:
                begin
                    f = 8'($urandom);
                    apply_config(f, f ^ 8'($urandom_range(1, 255)), 8'($urandom),
                                 4'($urandom));
                end
            endcase
            stuff_odds = $urandom_range(3, 32);
            paused = 1'b0;
            push_raw(flag_cfg);
            stop_at = bytes_queued + 110;
            while (bytes_queued < stop_at)
            begin
                if (phase % 2 == 1 && !paused && bytes_queued >= stop_at - 55)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(0, 12),
                               -1, ($urandom_range(0, 3) == 0) ? FCS_BAD : FCS_GOOD);
                end
                else if (r < 85)
                begin
                    send_frame($urandom_range(0, 3), -1, FCS_NONE);
                end
                else
                begin
                    send_noise($urandom_range(1, 8));
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_events.size() == 0)
        begin
            $display("hdlc_byte_stuffed_deframer test passed");
        end
        else
        begin
            $display("hdlc_byte_stuffed_deframer test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/hbsd_pkg.sv
sv/hbsd_if.sv
sv/hdlc_byte_stuffed_deframer.sv
sv/hbsd_checker.sv
tb/hdlc_byte_stuffed_deframer_tb.sv
